### rtl/core/kdar_pkg.sv
// Shared types and constants for the key debounce / auto-repeat unit.
// Holds the register index codes, reset values and the config bundle.
// No dependencies.
package kdar_pkg;

  localparam int KeyBits   = 8;   // key lines in use, 1..8 (CodeW)
  localparam int CodeW     = 8;   // width of the sample and key code ports
  localparam int CountW    = 16;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 16;

  localparam logic [CountW-1:0] FirstDelayRst  = CountW'(50);
  localparam logic [CountW-1:0] RepeatDelayRst = CountW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    CfgAllowMulti   = 3'd0,
    CfgRepeatEnable = 3'd1,
    CfgRepeatAccel  = 3'd2,
    CfgFirstDelay   = 3'd3,
    CfgRepeatDelay  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic              allow_multi;
    logic              repeat_enable;
    logic              repeat_accel;
    logic [CountW-1:0] first_delay;
    logic [CountW-1:0] repeat_delay;
  } kdar_cfg_t;

  typedef struct packed {
    logic s1_valid;
  } kdar_status_t;

  // Keep only the low KeyBits lines of a sample.
  function automatic logic [CodeW-1:0] key_mask(input logic [CodeW-1:0] v);
    logic [CodeW-1:0] m;
    m = '0;
    for (int i = 0; i < KeyBits && i < CodeW; i++) begin
      m[i] = 1'b1;
    end
    return v & m;
  endfunction

endpackage

### rtl/core/kdar_cfg.sv
// Configuration register file of the key debounce / auto-repeat unit.
// Depends on kdar_pkg for register codes and reset values.
module kdar_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kdar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kdar_pkg::CfgDataW-1:0] cfg_data_i,
  output kdar_pkg::kdar_cfg_t          cfg_o
);
  import kdar_pkg::*;

  kdar_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgAllowMulti:   cfg_d.allow_multi   = cfg_data_i[0];
        CfgRepeatEnable: cfg_d.repeat_enable = cfg_data_i[0];
        CfgRepeatAccel:  cfg_d.repeat_accel  = cfg_data_i[0];
        CfgFirstDelay:   cfg_d.first_delay   = cfg_data_i[CountW-1:0];
        CfgRepeatDelay:  cfg_d.repeat_delay  = cfg_data_i[CountW-1:0];
        default:         cfg_d = cfg_q;  // unused index, drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.allow_multi   <= 1'b0;
      cfg_q.repeat_enable <= 1'b1;
      cfg_q.repeat_accel  <= 1'b1;
      cfg_q.first_delay   <= FirstDelayRst;
      cfg_q.repeat_delay  <= RepeatDelayRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/kdar_core.sv
// Scan datapath: input register, debounce/repeat logic, result register.
// Holds last key, hold count and hold limit. Depends on kdar_pkg.
module kdar_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kdar_pkg::kdar_cfg_t        cfg_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [kdar_pkg::CodeW-1:0] sample_first_i,
  input  logic [kdar_pkg::CodeW-1:0] sample_second_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [kdar_pkg::CodeW-1:0] key_code_o,
  output kdar_pkg::kdar_status_t     status_o
);
  import kdar_pkg::*;

  logic              s1_valid_q;
  logic [CodeW-1:0]  a_q, b_q;
  logic              out_valid_q;
  logic [CodeW-1:0]  key_q, key_d;

  logic [CodeW-1:0]  last_key_q, last_key_d;
  logic [CountW-1:0] hold_count_q, hold_count_d;
  logic [CountW-1:0] hold_limit_q, hold_limit_d;

  logic              out_load;
  logic              s1_load;
  logic              single;
  logic [CountW-1:0] count_inc;

  // Result register frees up when empty or when its request is taken.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_stall_o = !s1_load;

  assign single    = (a_q != '0) && ((a_q & (a_q - CodeW'(1))) == '0);
  assign count_inc = (hold_count_q != '1) ? hold_count_q + CountW'(1) : hold_count_q;

  always_comb begin
    last_key_d   = last_key_q;
    hold_count_d = hold_count_q;
    hold_limit_d = hold_limit_q;
    key_d        = '0;
    if (a_q != b_q) begin
      hold_count_d = '0;
    end else if (a_q == '0) begin
      last_key_d   = '0;
      hold_count_d = '0;
      hold_limit_d = cfg_i.first_delay;
    end else if (last_key_q != a_q) begin
      hold_count_d = '0;
      last_key_d   = a_q;
      if (cfg_i.allow_multi || single) begin
        key_d = a_q;
      end
    end else if ((!cfg_i.allow_multi && !single) || !cfg_i.repeat_enable) begin
      hold_count_d = '0;
    end else begin
      hold_count_d = count_inc;
      if (count_inc > hold_limit_q) begin
        hold_count_d = '0;
        if (cfg_i.repeat_accel && (hold_limit_q == cfg_i.first_delay)) begin
          hold_limit_d = cfg_i.repeat_delay;
        end
        key_d = a_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      last_key_q   <= '0;
      hold_count_q <= '0;
      hold_limit_q <= FirstDelayRst;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      // Advance scan state only when the request moves into the result register.
      if (s1_valid_q && out_load) begin
        last_key_q   <= last_key_d;
        hold_count_q <= hold_count_d;
        hold_limit_q <= hold_limit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_valid_i) begin
      a_q <= key_mask(sample_first_i);
      b_q <= key_mask(sample_second_i);
    end
    if (out_load && s1_valid_q) begin
      key_q <= key_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_code_o        = key_q;
  assign status_o.s1_valid = s1_valid_q;

endmodule

### rtl/core/key_debounce_auto_repeat_unit.sv
// Key debounce with auto-repeat, top level.
// A request goes through the input register, then the result register.
// Throughput: one scan per cycle while out_stall_i does not hold a result.
// Reset: async active low; last key and hold count clear, hold limit = 50,
// config registers return to allow_multi=0, repeat on, accel on, 50, 10.
// Depends on kdar_pkg, kdar_cfg and kdar_core.
module key_debounce_auto_repeat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kdar_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kdar_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [kdar_pkg::CodeW-1:0]    sample_first_i,
  input  logic [kdar_pkg::CodeW-1:0]    sample_second_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [kdar_pkg::CodeW-1:0]    key_code_o
);
  import kdar_pkg::*;

  kdar_cfg_t    cfg;
  kdar_status_t status;

  kdar_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kdar_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_first_i  (sample_first_i),
    .sample_second_i (sample_second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .key_code_o      (key_code_o),
    .status_o        (status)
  );

  // Input side only backs up when the result register is full and held.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (status.s1_valid && out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // An accepted request lands in the input register.
  a_accept_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> status.s1_valid)
    else $error("accepted request lost");

  // A request leaving the input register shows up as a result.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.s1_valid && !(out_valid_o && out_stall_i)) |=> out_valid_o)
    else $error("request did not reach the result register");

endmodule
